// File: design/ppuv_pkg.sv
// ----------------------------------------------------------------------------
// Planar UV projector package
// Shared widths, register indexes, reset values and the configuration bundle
// used by all stages of the planar point to UV projector.
// ----------------------------------------------------------------------------
package ppuv_pkg;

    localparam int COORD_WIDTH_DEF  = 21;
    localparam int UV_FRAC_BITS_DEF = 20;

    localparam int PACK_W     = 21;
    localparam int AXIS_FRAC  = 19;
    localparam int TRIG_FRAC  = 14;
    localparam int INV_FRAC   = 24;
    localparam int DEPTH_W    = 26;
    localparam int XY_W       = 32;
    localparam int UVC_W      = 42;
    localparam int UV_W       = 32;
    localparam int TRIG_W     = 16;
    localparam int PROD_W     = 64;
    localparam int CFG_W      = 63;
    localparam int CFG_IDX_W  = 4;
    localparam int XY_CLAMP_LOG  = 30;
    localparam int UVC_CLAMP_LOG = 40;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_W    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_H    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COS_SIN  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR   = 4'd7;

    typedef struct packed {
        logic [CFG_W-1:0] origin;
        logic [CFG_W-1:0] right_axis;
        logic [CFG_W-1:0] up_axis;
        logic [CFG_W-1:0] normal_axis;
        logic [31:0]      inv_width;
        logic [31:0]      inv_height;
        logic [31:0]      cos_sin;
        logic [1:0]       mirror;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        origin:      63'd0,
        right_axis:  63'd1 << AXIS_FRAC,
        up_axis:     63'd1 << (AXIS_FRAC + PACK_W),
        normal_axis: 63'd1 << (AXIS_FRAC + 2 * PACK_W),
        inv_width:   32'd167772,
        inv_height:  32'd167772,
        cos_sin:     32'd1 << (16 + TRIG_FRAC),
        mirror:      2'd0
    };

endpackage

// File: design/ppuv_dot.sv
// ----------------------------------------------------------------------------
// Planar UV projector: frame transform
// Three stages: offset from the origin, nine axis products, then the three
// rounded and clamped dot products giving x, y and depth.
// ----------------------------------------------------------------------------
module ppuv_dot #(
    parameter int COORD_WIDTH = ppuv_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [COORD_WIDTH-1:0]         i_point_x,
    input  logic signed [COORD_WIDTH-1:0]         i_point_y,
    input  logic signed [COORD_WIDTH-1:0]         i_point_z,
    input  ppuv_pkg::t_cfg                        i_cfg,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [ppuv_pkg::XY_W-1:0]      o_xs,
    output logic signed [ppuv_pkg::XY_W-1:0]      o_ys,
    output logic signed [ppuv_pkg::DEPTH_W-1:0]   o_depth
);

    localparam int PW_ = ppuv_pkg::PACK_W;
    localparam int DW  = ((COORD_WIDTH > PW_) ? COORD_WIDTH : PW_) + 1;
    localparam int PW  = DW + PW_;
    localparam int SW  = PW + 2;
    localparam int KW  = ((DW + 4) > 33) ? (DW + 4) : 33;

    localparam logic signed [SW-1:0] HALF_AX = SW'(2 ** (ppuv_pkg::AXIS_FRAC - 1));
    localparam logic signed [KW-1:0] XY_HI   = KW'(2 ** ppuv_pkg::XY_CLAMP_LOG);
    localparam logic signed [KW-1:0] XY_LO   = -XY_HI;
    localparam logic signed [KW-1:0] DEP_HI  = KW'(2 ** (ppuv_pkg::DEPTH_W - 1) - 1);
    localparam logic signed [KW-1:0] DEP_LO  = -DEP_HI - KW'(1);

    function automatic logic signed [KW-1:0] clamp_k(
        input logic signed [KW-1:0] v,
        input logic signed [KW-1:0] lo,
        input logic signed [KW-1:0] hi
    );
        logic signed [KW-1:0] r;
        r = v;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end
        return r;
    endfunction

    logic signed [COORD_WIDTH-1:0] w_pt  [3];
    logic signed [PW_-1:0]         w_org [3];
    logic signed [PW_-1:0]         w_ax  [3][3];

    logic signed [DW-1:0] n_d    [3];
    logic signed [DW-1:0] r_d    [3];
    logic signed [PW-1:0] n_prod [3][3];
    logic signed [PW-1:0] r_prod [3][3];
    logic signed [SW-1:0] t_sum  [3];
    logic signed [KW-1:0] t_rnd  [3];

    logic signed [ppuv_pkg::XY_W-1:0]    n_xs, n_ys, r_xs, r_ys;
    logic signed [ppuv_pkg::DEPTH_W-1:0] n_depth, r_depth;

    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v3;

    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_org[k]   = i_cfg.origin[k*PW_ +: PW_];
            w_ax[0][k] = i_cfg.right_axis[k*PW_ +: PW_];
            w_ax[1][k] = i_cfg.up_axis[k*PW_ +: PW_];
            w_ax[2][k] = i_cfg.normal_axis[k*PW_ +: PW_];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_d[k] = DW'(w_pt[k]) - DW'(w_org[k]);
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[a][k] = PW'(r_d[k]) * PW'(w_ax[a][k]);
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            t_sum[a] = SW'(r_prod[a][0]) + SW'(r_prod[a][1]) + SW'(r_prod[a][2]) + HALF_AX;
            t_rnd[a] = KW'(t_sum[a] >>> ppuv_pkg::AXIS_FRAC);
        end
        n_xs    = ppuv_pkg::XY_W'(clamp_k(t_rnd[0], XY_LO, XY_HI));
        n_ys    = ppuv_pkg::XY_W'(clamp_k(t_rnd[1], XY_LO, XY_HI));
        n_depth = ppuv_pkg::DEPTH_W'(clamp_k(t_rnd[2], DEP_LO, DEP_HI));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_d <= n_d;
        end
        if (w_en2 && r_v1) begin
            r_prod <= n_prod;
        end
        if (w_en3 && r_v2) begin
            r_xs    <= n_xs;
            r_ys    <= n_ys;
            r_depth <= n_depth;
        end
    end

    assign o_xs    = r_xs;
    assign o_ys    = r_ys;
    assign o_depth = r_depth;

endmodule

// File: design/ppuv_scale.sv
// ----------------------------------------------------------------------------
// Planar UV projector: plane scaling
// Two stages: multiply x and y by the reciprocal plane sizes, then round to
// the UV fraction, negate v and clamp both to the working range.
// ----------------------------------------------------------------------------
module ppuv_scale #(
    parameter int UV_FRAC_BITS = ppuv_pkg::UV_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ppuv_pkg::XY_W-1:0]    i_xs,
    input  logic signed [ppuv_pkg::XY_W-1:0]    i_ys,
    input  ppuv_pkg::t_cfg                      i_cfg,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ppuv_pkg::UVC_W-1:0]   o_uc,
    output logic signed [ppuv_pkg::UVC_W-1:0]   o_vc
);

    localparam int MW = ppuv_pkg::PROD_W;
    localparam int EW = MW + 1;
    localparam int SH = 8 + ppuv_pkg::INV_FRAC - UV_FRAC_BITS;

    localparam logic signed [EW-1:0] RND   = EW'(2 ** (SH - 1));
    localparam logic signed [EW-1:0] UC_HI = EW'(64'sd1 <<< ppuv_pkg::UVC_CLAMP_LOG);
    localparam logic signed [EW-1:0] UC_LO = -UC_HI;

    function automatic logic signed [EW-1:0] clamp_e(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] r;
        r = v;
        if (v > UC_HI) begin
            r = UC_HI;
        end else if (v < UC_LO) begin
            r = UC_LO;
        end
        return r;
    endfunction

    logic signed [MW-1:0] n_pu, n_pv, r_pu, r_pv;
    logic signed [EW-1:0] t_u, t_v, t_ru, t_rv;
    logic signed [ppuv_pkg::UVC_W-1:0] n_uc, n_vc, r_uc, r_vc;

    logic r_v1, r_v2;
    logic w_en1, w_en2;

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v2;

    always_comb begin
        n_pu = MW'(i_xs) * MW'($signed({1'b0, i_cfg.inv_width}));
        n_pv = MW'(i_ys) * MW'($signed({1'b0, i_cfg.inv_height}));
    end

    always_comb begin
        t_u  = EW'(r_pu) + RND;
        t_v  = EW'(r_pv) + RND;
        t_ru = t_u >>> SH;
        t_rv = -(t_v >>> SH);
        n_uc = ppuv_pkg::UVC_W'(clamp_e(t_ru));
        n_vc = ppuv_pkg::UVC_W'(clamp_e(t_rv));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_pu <= n_pu;
            r_pv <= n_pv;
        end
        if (w_en2 && r_v1) begin
            r_uc <= n_uc;
            r_vc <= n_vc;
        end
    end

    assign o_uc = r_uc;
    assign o_vc = r_vc;

endmodule

// File: design/ppuv_rotate.sv
// ----------------------------------------------------------------------------
// Planar UV projector: rotation and output
// Three stages: the four rotation products, the rounded rotated pair, then
// mirroring, the half offset, saturation and the unit square test.
// ----------------------------------------------------------------------------
module ppuv_rotate #(
    parameter int UV_FRAC_BITS = ppuv_pkg::UV_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ppuv_pkg::UVC_W-1:0]   i_uc,
    input  logic signed [ppuv_pkg::UVC_W-1:0]   i_vc,
    input  logic signed [ppuv_pkg::DEPTH_W-1:0] i_depth,
    input  ppuv_pkg::t_cfg                      i_cfg,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ppuv_pkg::UV_W-1:0]    o_u_coord,
    output logic signed [ppuv_pkg::UV_W-1:0]    o_v_coord,
    output logic signed [ppuv_pkg::DEPTH_W-1:0] o_depth,
    output logic                                o_inside_res
);

    localparam int PR = ppuv_pkg::UVC_W + ppuv_pkg::TRIG_W;
    localparam int AW = PR + 1;
    localparam int RR = AW - ppuv_pkg::TRIG_FRAC;
    localparam int QW = RR + 2;
    localparam int OW = ppuv_pkg::UV_W;

    localparam logic signed [AW-1:0] HALF_T  = AW'(2 ** (ppuv_pkg::TRIG_FRAC - 1));
    localparam logic signed [QW-1:0] HALF_UV = QW'(2 ** (UV_FRAC_BITS - 1));
    localparam logic signed [QW-1:0] SAT_HI  = QW'(2 ** (OW - 1) - 1);
    localparam logic signed [QW-1:0] SAT_LO  = -SAT_HI - QW'(1);
    localparam logic signed [OW-1:0] UV_ONE  = OW'(2 ** UV_FRAC_BITS);

    function automatic logic signed [OW-1:0] sat_q(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] r;
        r = v;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end
        return OW'(r);
    endfunction

    logic signed [ppuv_pkg::TRIG_W-1:0] w_c, w_s;

    logic signed [PR-1:0] n_cu, n_sv, n_cv, n_su, r_cu, r_sv, r_cv, r_su;
    logic signed [AW-1:0] t_u, t_v;
    logic signed [RR-1:0] n_u2, n_v2, r_u2, r_v2;
    logic signed [QW-1:0] t_wu, t_wv;
    logic signed [OW-1:0] n_u, n_v, r_u, r_v;
    logic                 n_inside, r_inside;

    logic signed [ppuv_pkg::DEPTH_W-1:0] r_dep6, r_dep7, r_dep8;

    logic r_vl6, r_vl7, r_vl8;
    logic w_en6, w_en7, w_en8;

    assign w_en8   = !r_vl8 || i_ready;
    assign w_en7   = !r_vl7 || w_en8;
    assign w_en6   = !r_vl6 || w_en7;
    assign o_ready = w_en6;
    assign o_valid = r_vl8;

    assign w_c = i_cfg.cos_sin[31:16];
    assign w_s = i_cfg.cos_sin[15:0];

    always_comb begin
        n_cu = PR'(i_uc) * PR'(w_c);
        n_sv = PR'(i_vc) * PR'(w_s);
        n_cv = PR'(i_vc) * PR'(w_c);
        n_su = PR'(i_uc) * PR'(w_s);
    end

    always_comb begin
        t_u  = AW'(r_cu) + AW'(r_sv) + HALF_T;
        t_v  = AW'(r_cv) - AW'(r_su) + HALF_T;
        n_u2 = RR'(t_u >>> ppuv_pkg::TRIG_FRAC);
        n_v2 = RR'(t_v >>> ppuv_pkg::TRIG_FRAC);
    end

    always_comb begin
        t_wu     = i_cfg.mirror[0] ? (HALF_UV - QW'(r_u2)) : (HALF_UV + QW'(r_u2));
        t_wv     = i_cfg.mirror[1] ? (HALF_UV - QW'(r_v2)) : (HALF_UV + QW'(r_v2));
        n_u      = sat_q(t_wu);
        n_v      = sat_q(t_wv);
        n_inside = (n_u >= 0) && (n_u <= UV_ONE) && (n_v >= 0) && (n_v <= UV_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl6 <= 1'b0;
            r_vl7 <= 1'b0;
            r_vl8 <= 1'b0;
        end else begin
            if (w_en6) begin
                r_vl6 <= i_valid;
            end
            if (w_en7) begin
                r_vl7 <= r_vl6;
            end
            if (w_en8) begin
                r_vl8 <= r_vl7;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en6 && i_valid) begin
            r_cu   <= n_cu;
            r_sv   <= n_sv;
            r_cv   <= n_cv;
            r_su   <= n_su;
            r_dep6 <= i_depth;
        end
        if (w_en7 && r_vl6) begin
            r_u2   <= n_u2;
            r_v2   <= n_v2;
            r_dep7 <= r_dep6;
        end
        if (w_en8 && r_vl7) begin
            r_u      <= n_u;
            r_v      <= n_v;
            r_inside <= n_inside;
            r_dep8   <= r_dep7;
        end
    end

    assign o_u_coord    = r_u;
    assign o_v_coord    = r_v;
    assign o_depth      = r_dep8;
    assign o_inside_res = r_inside;

endmodule

// File: design/planar_point_to_uv_projector.sv
// ----------------------------------------------------------------------------
// Planar point to UV projector
// Projects 3D points onto a configured plane and returns texture
// coordinates, depth and an inside flag.
// ----------------------------------------------------------------------------
// Usage: points arrive on the input channel (i_valid, o_stall) with one
// coordinate per port; one result leaves on the output channel (o_valid,
// i_stall) for every point, in order. Each transfer happens on a rising edge
// where valid is high and stall is low.
// The pipeline accepts one point per cycle while o_stall is low; the rate is
// set by the eight register stages, each of which advances whenever the stage
// after it is empty or moving.
// The user must write the frame, reciprocals, rotation and mirror flags over
// the plain write port (i_cfg_we, i_cfg_idx, i_cfg_data) only while no point
// is in flight; the block does not enforce this. Unknown indexes are ignored.
// Reset clears every stage and returns the registers to the identity frame,
// no rotation and no mirroring.
// When the receiver stalls, the held result stays on the outputs, empty
// stages keep filling, and o_stall rises once no stage can move.
// ----------------------------------------------------------------------------
module planar_point_to_uv_projector #(
    parameter int COORD_WIDTH  = ppuv_pkg::COORD_WIDTH_DEF,
    parameter int UV_FRAC_BITS = ppuv_pkg::UV_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ppuv_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ppuv_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [COORD_WIDTH-1:0]         i_point_x,
    input  logic signed [COORD_WIDTH-1:0]         i_point_y,
    input  logic signed [COORD_WIDTH-1:0]         i_point_z,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [ppuv_pkg::UV_W-1:0]      o_u_coord,
    output logic signed [ppuv_pkg::UV_W-1:0]      o_v_coord,
    output logic signed [ppuv_pkg::DEPTH_W-1:0]   o_depth,
    output logic                                  o_inside_res
);

    ppuv_pkg::t_cfg r_cfg;

    logic w_dot_ready, w_dot_valid;
    logic w_scl_ready, w_scl_valid;
    logic w_rot_ready;

    logic signed [ppuv_pkg::XY_W-1:0]    w_xs, w_ys;
    logic signed [ppuv_pkg::DEPTH_W-1:0] w_depth;
    logic signed [ppuv_pkg::DEPTH_W-1:0] r_depth_s4, r_depth_s5;
    logic signed [ppuv_pkg::UVC_W-1:0]   w_uc, w_vc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ppuv_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppuv_pkg::REG_ORIGIN:  r_cfg.origin      <= i_cfg_data;
                ppuv_pkg::REG_RIGHT:   r_cfg.right_axis  <= i_cfg_data;
                ppuv_pkg::REG_UP:      r_cfg.up_axis     <= i_cfg_data;
                ppuv_pkg::REG_NORMAL:  r_cfg.normal_axis <= i_cfg_data;
                ppuv_pkg::REG_INV_W:   r_cfg.inv_width   <= i_cfg_data[31:0];
                ppuv_pkg::REG_INV_H:   r_cfg.inv_height  <= i_cfg_data[31:0];
                ppuv_pkg::REG_COS_SIN: r_cfg.cos_sin     <= i_cfg_data[31:0];
                ppuv_pkg::REG_MIRROR:  r_cfg.mirror      <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    ppuv_dot #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (w_dot_ready),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_cfg     (r_cfg),
        .o_valid   (w_dot_valid),
        .i_ready   (w_scl_ready),
        .o_xs      (w_xs),
        .o_ys      (w_ys),
        .o_depth   (w_depth)
    );

    ppuv_scale #(
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dot_valid),
        .o_ready (w_scl_ready),
        .i_xs    (w_xs),
        .i_ys    (w_ys),
        .i_cfg   (r_cfg),
        .o_valid (w_scl_valid),
        .i_ready (w_rot_ready),
        .o_uc    (w_uc),
        .o_vc    (w_vc)
    );

    // Depth rides alongside the two scaling stages, moving with them.
    always_ff @(posedge i_clk) begin
        if (w_scl_ready && w_dot_valid) begin
            r_depth_s4 <= w_depth;
        end
        if (!w_scl_valid || w_rot_ready) begin
            r_depth_s5 <= r_depth_s4;
        end
    end

    ppuv_rotate #(
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_rotate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_scl_valid),
        .o_ready      (w_rot_ready),
        .i_uc         (w_uc),
        .i_vc         (w_vc),
        .i_depth      (r_depth_s5),
        .i_cfg        (r_cfg),
        .o_valid      (o_valid),
        .i_ready      (!i_stall),
        .o_u_coord    (o_u_coord),
        .o_v_coord    (o_v_coord),
        .o_depth      (o_depth),
        .o_inside_res (o_inside_res)
    );

    assign o_stall = !w_dot_ready;

`ifndef NO_ASSERTIONS
    localparam logic signed [ppuv_pkg::UV_W-1:0] AST_ONE = ppuv_pkg::UV_W'(2 ** UV_FRAC_BITS);

    a_empty_out_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while the output register is empty");

    a_free_out_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while the receiver takes results");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid directly after reset");

    a_inside_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_inside_res) |->
            (o_u_coord >= 0 && o_u_coord <= AST_ONE &&
             o_v_coord >= 0 && o_v_coord <= AST_ONE))
        else $error("inside flag set for a point outside the unit square");
`endif

endmodule

// File: test/planar_point_to_uv_projector_test.sv
// ----------------------------------------------------------------------------
// Planar point to UV projector testbench
// Drives points through the valid/stall input channel and checks every
// result against a predictor of the projection kept in the testbench: frame
// dot products, reciprocal scaling, rotation, mirroring, saturation and the
// inside flag. The frame registers are rewritten between phases while the
// pipeline is empty. Directed phases cover the reset frame, extreme
// registers, zero reciprocals, dropped high bits and a rotation that cancels
// two clamped terms; random phases follow, with and without idling.
// ----------------------------------------------------------------------------
module planar_point_to_uv_projector_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W     = ppuv_pkg::COORD_WIDTH_DEF;
    localparam int UV_FRAC     = ppuv_pkg::UV_FRAC_BITS_DEF;
    localparam int UV_SHIFT    = 8 + ppuv_pkg::INV_FRAC - UV_FRAC;
    localparam int PACK_W      = ppuv_pkg::PACK_W;
    localparam int CFG_W       = ppuv_pkg::CFG_W;
    localparam int CFG_IDX_W   = ppuv_pkg::CFG_IDX_W;
    localparam int UV_W        = ppuv_pkg::UV_W;
    localparam int DEPTH_W     = ppuv_pkg::DEPTH_W;
    localparam int TRIG_W      = ppuv_pkg::TRIG_W;
    localparam int AXIS_FRAC   = ppuv_pkg::AXIS_FRAC;
    localparam int TRIG_FRAC   = ppuv_pkg::TRIG_FRAC;
    localparam int PIPE_DEPTH  = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 16;

    localparam logic signed [COORD_W-1:0] PT_MAX = COORD_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [COORD_W-1:0] PT_MIN = COORD_W'(-(1 << (COORD_W - 1)));
    localparam int LANE_MAX = (1 << (PACK_W - 1)) - 1;
    localparam int LANE_MIN = -(1 << (PACK_W - 1));

    localparam longint XY_LIM    = 64'sd1 << ppuv_pkg::XY_CLAMP_LOG;
    localparam longint UV_LIM    = 64'sd1 << ppuv_pkg::UVC_CLAMP_LOG;
    localparam longint DEPTH_MAX = (64'sd1 <<< (DEPTH_W - 1)) - 1;
    localparam longint DEPTH_MIN = -(64'sd1 <<< (DEPTH_W - 1));
    localparam longint UV_HALF   = 64'sd1 <<< (UV_FRAC - 1);
    localparam longint UV_ONE    = 64'sd1 <<< UV_FRAC;
    localparam longint WORD_MAX  = (64'sd1 <<< 31) - 1;
    localparam longint WORD_MIN  = -(64'sd1 <<< 31);

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = ppuv_pkg::REG_MIRROR + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    typedef struct packed {
        logic signed [UV_W-1:0]    u;
        logic signed [UV_W-1:0]    v;
        logic signed [DEPTH_W-1:0] depth;
        logic                      in_square;
    } t_uv_result;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx  = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       i_valid    = 1'b0;
    logic                       o_stall;
    logic signed [COORD_W-1:0]  i_point_x  = '0;
    logic signed [COORD_W-1:0]  i_point_y  = '0;
    logic signed [COORD_W-1:0]  i_point_z  = '0;
    logic                       o_valid;
    logic                       i_stall    = 1'b0;
    logic signed [UV_W-1:0]     o_u_coord;
    logic signed [UV_W-1:0]     o_v_coord;
    logic signed [DEPTH_W-1:0]  o_depth;
    logic                       o_inside_res;

    ppuv_pkg::t_cfg frame;
    t_uv_result     projected_q[$];
    t_uv_result     head;
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count    = 0;
    logic           calm           = 1'b0;

    planar_point_to_uv_projector dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (projected_q.size() == 0) begin
                $display("%0t: unexpected result u %0d v %0d depth %0d inside %0b", $time,
                         o_u_coord, o_v_coord, o_depth, o_inside_res);
                mismatch_count++;
            end else begin
                head = projected_q.pop_front();
                if (o_u_coord !== head.u) begin
                    $display("%0t: u_coord expected %0d actual %0d", $time, head.u, o_u_coord);
                    mismatch_count++;
                end
                if (o_v_coord !== head.v) begin
                    $display("%0t: v_coord expected %0d actual %0d", $time, head.v, o_v_coord);
                    mismatch_count++;
                end
                if (o_depth !== head.depth) begin
                    $display("%0t: depth expected %0d actual %0d", $time, head.depth, o_depth);
                    mismatch_count++;
                end
                if (o_inside_res !== head.in_square) begin
                    $display("%0t: inside_res expected %0b actual %0b", $time, head.in_square,
                             o_inside_res);
                    mismatch_count++;
                end
            end
        end
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    function automatic longint lane(input logic [CFG_W-1:0] word, input int k);
        logic signed [PACK_W-1:0] part;
        part = word[k*PACK_W +: PACK_W];
        return longint'(part);
    endfunction

    function automatic longint round_half_up(input longint value, input int shift);
        return (value + (64'sd1 <<< (shift - 1))) >>> shift;
    endfunction

    function automatic longint clip(input longint value, input longint lo, input longint hi);
        return (value < lo) ? lo : ((value > hi) ? hi : value);
    endfunction

    function automatic longint plane_dot(input longint dx, input longint dy, input longint dz,
                                         input logic [CFG_W-1:0] axis);
        return dx * lane(axis, 0) + dy * lane(axis, 1) + dz * lane(axis, 2);
    endfunction

    function automatic t_uv_result project_point(input logic signed [COORD_W-1:0] px,
                                                 input logic signed [COORD_W-1:0] py,
                                                 input logic signed [COORD_W-1:0] pz);
        longint dx, dy, dz, xs, ys, dep, uc, vc, c, s, u2, v2;
        logic signed [TRIG_W-1:0] cos_q, sin_q;
        t_uv_result r;
        dx = longint'(px) - lane(frame.origin, 0);
        dy = longint'(py) - lane(frame.origin, 1);
        dz = longint'(pz) - lane(frame.origin, 2);
        xs = clip(round_half_up(plane_dot(dx, dy, dz, frame.right_axis), AXIS_FRAC),
                  -XY_LIM, XY_LIM);
        ys = clip(round_half_up(plane_dot(dx, dy, dz, frame.up_axis), AXIS_FRAC),
                  -XY_LIM, XY_LIM);
        dep = clip(round_half_up(plane_dot(dx, dy, dz, frame.normal_axis), AXIS_FRAC),
                   DEPTH_MIN, DEPTH_MAX);
        uc = round_half_up(xs * longint'(frame.inv_width), UV_SHIFT);
        vc = -round_half_up(ys * longint'(frame.inv_height), UV_SHIFT);
        uc = clip(uc, -UV_LIM, UV_LIM);
        vc = clip(vc, -UV_LIM, UV_LIM);
        cos_q = frame.cos_sin[31:16];
        sin_q = frame.cos_sin[15:0];
        c = longint'(cos_q);
        s = longint'(sin_q);
        u2 = round_half_up(c * uc + s * vc, TRIG_FRAC);
        v2 = round_half_up(c * vc - s * uc, TRIG_FRAC);
        if (frame.mirror[0]) u2 = -u2;
        if (frame.mirror[1]) v2 = -v2;
        u2 = clip(u2 + UV_HALF, WORD_MIN, WORD_MAX);
        v2 = clip(v2 + UV_HALF, WORD_MIN, WORD_MAX);
        r.u = u2[UV_W-1:0];
        r.v = v2[UV_W-1:0];
        r.depth = dep[DEPTH_W-1:0];
        r.in_square = (u2 >= 0 && u2 <= UV_ONE && v2 >= 0 && v2 <= UV_ONE);
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] pack3(input int a, input int b, input int c);
        return {c[PACK_W-1:0], b[PACK_W-1:0], a[PACK_W-1:0]};
    endfunction

    function automatic int spread(input int span);
        int v;
        v = int'($urandom_range(2 * span));
        return v - span;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            ppuv_pkg::REG_ORIGIN:  frame.origin      = value;
            ppuv_pkg::REG_RIGHT:   frame.right_axis  = value;
            ppuv_pkg::REG_UP:      frame.up_axis     = value;
            ppuv_pkg::REG_NORMAL:  frame.normal_axis = value;
            ppuv_pkg::REG_INV_W:   frame.inv_width   = value[31:0];
            ppuv_pkg::REG_INV_H:   frame.inv_height  = value[31:0];
            ppuv_pkg::REG_COS_SIN: frame.cos_sin     = value[31:0];
            ppuv_pkg::REG_MIRROR:  frame.mirror      = value[1:0];
            default: ;
        endcase
    endtask

    task automatic send_point(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py,
                              input logic signed [COORD_W-1:0] pz);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        i_point_z <= pz;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        projected_q.push_back(project_point(px, py, pz));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (projected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    task automatic send_random_points(input int count);
        logic signed [COORD_W-1:0] px, py, pz;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) < 6) begin
                px = COORD_W'(spread(1 << 14));
                py = COORD_W'(spread(1 << 14));
                pz = COORD_W'(spread(1 << 14));
            end else begin
                px = COORD_W'($urandom);
                py = COORD_W'($urandom);
                pz = COORD_W'($urandom);
            end
            send_point(px, py, pz);
        end
    endtask

    task automatic load_random_frame();
        logic [CFG_W-1:0] noise;
        logic [15:0]      cos_r, sin_r;
        if ($urandom_range(2) == 0) begin
            for (int k = ppuv_pkg::REG_ORIGIN; k <= ppuv_pkg::REG_MIRROR; k++) begin
                noise = CFG_W'({$urandom, $urandom});
                write_reg(k[CFG_IDX_W-1:0], noise);
            end
        end else begin
            write_reg(ppuv_pkg::REG_ORIGIN,
                      pack3(spread(1 << 12), spread(1 << 12), spread(1 << 12)));
            write_reg(ppuv_pkg::REG_RIGHT,
                      pack3(spread(1 << 19), spread(1 << 19), spread(1 << 19)));
            write_reg(ppuv_pkg::REG_UP,
                      pack3(spread(1 << 19), spread(1 << 19), spread(1 << 19)));
            write_reg(ppuv_pkg::REG_NORMAL,
                      pack3(spread(1 << 19), spread(1 << 19), spread(1 << 19)));
            write_reg(ppuv_pkg::REG_INV_W, CFG_W'($urandom_range(1 << 19, 1 << 15)));
            write_reg(ppuv_pkg::REG_INV_H, CFG_W'($urandom_range(1 << 19, 1 << 15)));
            if ($urandom_range(1) == 0) begin
                write_reg(ppuv_pkg::REG_COS_SIN, CFG_W'(ppuv_pkg::CFG_RESET.cos_sin));
            end else begin
                cos_r = 16'(spread(1 << 14));
                sin_r = 16'(spread(1 << 14));
                write_reg(ppuv_pkg::REG_COS_SIN, CFG_W'({cos_r, sin_r}));
            end
            write_reg(ppuv_pkg::REG_MIRROR, CFG_W'($urandom_range(3)));
        end
        if ($urandom_range(3) == 0) begin
            noise = CFG_W'({$urandom, $urandom});
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), noise);
        end
    endtask

    task automatic test_reset_frame();
        send_point('0, '0, '0);
        send_point(PT_MAX, PT_MAX, PT_MAX);
        send_point(PT_MIN, PT_MIN, PT_MIN);
        send_point(PT_MAX, PT_MIN, '0);
        send_point(COORD_W'(12800), COORD_W'(-12800), COORD_W'(1));
        settle();
    endtask

    task automatic test_extreme_frame();
        write_reg(ppuv_pkg::REG_ORIGIN, pack3(LANE_MIN, LANE_MAX, LANE_MIN));
        write_reg(ppuv_pkg::REG_RIGHT, pack3(LANE_MIN, LANE_MIN, LANE_MIN));
        write_reg(ppuv_pkg::REG_UP, pack3(LANE_MAX, LANE_MIN, LANE_MAX));
        write_reg(ppuv_pkg::REG_NORMAL, pack3(LANE_MAX, LANE_MAX, LANE_MAX));
        write_reg(ppuv_pkg::REG_INV_W, CFG_W'(32'hFFFF_FFFF));
        write_reg(ppuv_pkg::REG_INV_H, CFG_W'(32'hFFFF_FFFF));
        write_reg(ppuv_pkg::REG_COS_SIN, CFG_W'({16'h8000, 16'h7FFF}));
        write_reg(ppuv_pkg::REG_MIRROR, CFG_W'(2'b11));
        send_point(PT_MIN, PT_MIN, PT_MIN);
        send_point(PT_MAX, PT_MAX, PT_MAX);
        send_point('0, '0, '0);
        send_point(PT_MIN, PT_MAX, PT_MIN);
        settle();
    endtask

    task automatic test_zero_reciprocal();
        write_reg(ppuv_pkg::REG_ORIGIN, ppuv_pkg::CFG_RESET.origin);
        write_reg(ppuv_pkg::REG_RIGHT, ppuv_pkg::CFG_RESET.right_axis);
        write_reg(ppuv_pkg::REG_UP, ppuv_pkg::CFG_RESET.up_axis);
        write_reg(ppuv_pkg::REG_NORMAL, ppuv_pkg::CFG_RESET.normal_axis);
        write_reg(ppuv_pkg::REG_INV_W, '0);
        write_reg(ppuv_pkg::REG_INV_H, '0);
        write_reg(ppuv_pkg::REG_COS_SIN, CFG_W'(ppuv_pkg::CFG_RESET.cos_sin));
        write_reg(ppuv_pkg::REG_MIRROR, CFG_W'(2'b01));
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, CFG_W'({$urandom, $urandom}));
        send_point(PT_MAX, PT_MIN, PT_MAX);
        send_point(COORD_W'(spread(1 << 14)), COORD_W'(spread(1 << 14)),
                   COORD_W'(spread(1 << 14)));
        send_point(PT_MIN, PT_MAX, '0);
        settle();
    endtask

    task automatic test_dropped_high_bits();
        write_reg(ppuv_pkg::REG_INV_W, '1);
        write_reg(ppuv_pkg::REG_INV_H, {31'h7FFF_FFFF, 32'h0000_4000});
        write_reg(ppuv_pkg::REG_COS_SIN, '1);
        write_reg(ppuv_pkg::REG_MIRROR, {{(CFG_W - 2){1'b1}}, 2'b10});
        send_point(COORD_W'(1), COORD_W'(-1), '0);
        send_point(PT_MAX, PT_MAX, PT_MIN);
        send_point(COORD_W'(spread(1 << 10)), COORD_W'(spread(1 << 10)),
                   COORD_W'(spread(1 << 10)));
        settle();
    endtask

    task automatic test_rotation_cancel();
        write_reg(ppuv_pkg::REG_ORIGIN, '0);
        write_reg(ppuv_pkg::REG_RIGHT, pack3(LANE_MAX, LANE_MAX, LANE_MAX));
        write_reg(ppuv_pkg::REG_UP, pack3(LANE_MAX, LANE_MAX, LANE_MAX));
        write_reg(ppuv_pkg::REG_INV_W, CFG_W'(32'hFFFF_FFFF));
        write_reg(ppuv_pkg::REG_INV_H, CFG_W'(32'hFFFF_FFFF));
        write_reg(ppuv_pkg::REG_COS_SIN, CFG_W'({16'h4000, 16'h4000}));
        write_reg(ppuv_pkg::REG_MIRROR, CFG_W'(2'b00));
        send_point(PT_MAX, PT_MAX, PT_MAX);
        send_point(PT_MIN, PT_MIN, PT_MIN);
        send_point(PT_MAX, '0, PT_MIN);
        settle();
    endtask

    task automatic test_random_frames();
        for (int phase = 0; phase < 9; phase++) begin
            load_random_frame();
            send_random_points(64);
            settle();
        end
    endtask

    task automatic test_no_idle();
        load_random_frame();
        calm = 1'b1;
        send_random_points(110);
        settle();
        calm = 1'b0;
    endtask

    initial begin
        frame = ppuv_pkg::CFG_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_frame();
        test_extreme_frame();
        test_zero_reciprocal();
        test_dropped_high_bits();
        test_rotation_cancel();
        test_random_frames();
        test_no_idle();
        if (mismatch_count == 0 && projected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/ppuv_pkg.sv
design/ppuv_dot.sv
design/ppuv_scale.sv
design/ppuv_rotate.sv
design/planar_point_to_uv_projector.sv
test/planar_point_to_uv_projector_test.sv
